@@ src/tree_center_by_leaf_peeling_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Tree centre peeling unit: assertion macros
// Shared property wrappers for the concurrent checks in the RTL. Each macro
// expands to one labelled assertion clocked on the rising edge and disabled
// while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TREE_CENTER_BY_LEAF_PEELING_UNIT_ASSERT_SVH
`define TREE_CENTER_BY_LEAF_PEELING_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TCP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tcp_pkg.sv @@
// ----------------------------------------------------------------------------
// Tree centre peeling unit: shared package
// Field widths, the node store word, the controller states, the datapath
// operation codes and the status bundle returned to the controller.
// ----------------------------------------------------------------------------
package tcp_pkg;

    // Field widths
    localparam int ID_W  = 10;   // node id
    localparam int DEG_W = 10;   // degree counter, wraps
    localparam int CNT_W = 11;   // node count register

    // Default store depth
    localparam int MAX_NODES_DEF = 1024;

    // One entry of the node store
    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic [ID_W-1:0]  nxor;
    } node_word_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_RDA,
        ST_LD_WRA,
        ST_LD_RDB,
        ST_LD_WRB,
        ST_RUN_SEL,
        ST_EMIT_ONE,
        ST_SCAN,
        ST_ROUND,
        ST_POP,
        ST_POP_WAIT,
        ST_LEAF_CHK,
        ST_NB_UPD,
        ST_EMIT0,
        ST_EMIT0_WAIT,
        ST_EMIT1,
        ST_EMIT1_WAIT
    } ctrl_state_t;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_LD_RD_A,
        OP_LD_WR_A,
        OP_LD_RD_B,
        OP_LD_WR_B,
        OP_RUN_INIT,
        OP_SCAN,
        OP_ROUND_START,
        OP_ROUND_END,
        OP_POP_RD,
        OP_LEAF_RD,
        OP_NB_RD,
        OP_NB_UPD,
        OP_HEAD_INC,
        OP_OUT_ZERO,
        OP_OUT_FIRST,
        OP_OUT_SECOND
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic in_range;    // both captured endpoints fit the store
        logic n_zero;      // effective node count is zero
        logic n_one;       // effective node count is one
        logic scan_done;   // leaf scan finished, last lookup retired
        logic peel_go;     // more than two nodes left and queue not empty
        logic round_busy;  // head has not reached the end of this round
        logic leaf_ok;     // popped leaf has a live degree and a valid neighbour
        logic q_empty;     // no queued entries remain
        logic q_one;       // exactly one queued entry remains
        logic clr_last;    // clearing sweep is at the last entry
    } dp_status_t;

endpackage

@@ src/tree_center_by_leaf_peeling_unit.sv @@
// ----------------------------------------------------------------------------
// Tree centre by leaf peeling
// Build a tree with one edge per input transaction (action 0), then send a
// run transaction (action 1): the unit returns up to two centre nodes,
// the last marked by m_last_center, and the stores are cleared for the next
// tree. node_count must be written before the run. All tree state sits in one
// node store (degree and neighbour XOR per node, one write and one registered
// read port) and a leaf queue, and an edge load is a read-modify-write of
// each endpoint in turn. A run scans nodes 0 to n-1, where n is
// min(node_count, MAX_NODES), then peels leaves round by round and ends in a
// clearing sweep over every node store entry, which also runs once after reset;
// s_ready is low during the sweep, configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module tree_center_by_leaf_peeling_unit #(
    parameter int MAX_NODES = tcp_pkg::MAX_NODES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [tcp_pkg::CNT_W-1:0] cfg_wr_data,
    // input transactions
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [tcp_pkg::ID_W-1:0]  s_edge_a,
    input  logic [tcp_pkg::ID_W-1:0]  s_edge_b,
    // result transactions
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [tcp_pkg::ID_W-1:0]  m_center_node,
    output logic                      m_last_center
);

    tcp_pkg::dp_op_t     op;
    tcp_pkg::dp_status_t status;

    // Sequencer
    tcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .op       (op)
    );

    // Stores, queue and result register
    tcp_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_edge_a      (s_edge_a),
        .s_edge_b      (s_edge_b),
        .op            (op),
        .status        (status),
        .m_center_node (m_center_node),
        .m_last_center (m_last_center)
    );

endmodule

@@ src/tcp_datapath.sv @@
// ----------------------------------------------------------------------------
// Tree centre peeling unit: datapath
// Node store (degree and neighbour XOR word), leaf queue, queue pointers,
// scan counter, node count register and the result register. Driven one
// operation per cycle by the controller.
// ----------------------------------------------------------------------------
module tcp_datapath #(
    parameter int MAX_NODES = tcp_pkg::MAX_NODES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [tcp_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic [tcp_pkg::ID_W-1:0]  s_edge_a,
    input  logic [tcp_pkg::ID_W-1:0]  s_edge_b,
    input  tcp_pkg::dp_op_t           op,
    output tcp_pkg::dp_status_t       status,
    output logic [tcp_pkg::ID_W-1:0]  m_center_node,
    output logic                      m_last_center
);

    localparam int AW = $clog2(MAX_NODES);          // store address
    localparam int PW = AW + 1;                     // queue pointers reach MAX_NODES
    localparam int CW = tcp_pkg::CNT_W;
    localparam int IW = tcp_pkg::ID_W;
    localparam int DW = tcp_pkg::DEG_W;
    localparam int LW = (PW > CW) ? PW : CW;        // compare width for counts

    // Storage
    tcp_pkg::node_word_t node_mem [MAX_NODES];
    logic [IW-1:0]       q_mem    [MAX_NODES];

    tcp_pkg::node_word_t node_rdata_reg;
    logic [IW-1:0]       q_rdata_reg;

    // Registers
    logic [CW-1:0] node_count_reg, node_count_next;
    logic [IW-1:0] edge_a_reg, edge_a_next;
    logic [IW-1:0] edge_b_reg, edge_b_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CW-1:0] scan_cnt_reg, scan_cnt_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_id_reg, pend_id_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] round_end_reg, round_end_next;
    logic [PW-1:0] taken_reg, taken_next;
    logic [CW-1:0] nodes_left_reg, nodes_left_next;
    logic [IW-1:0] nb_reg, nb_next;
    logic [IW-1:0] center_reg, center_next;
    logic          last_reg, last_next;

    // Memory port controls
    logic                node_we, node_re;
    logic [AW-1:0]       node_waddr, node_raddr;
    tcp_pkg::node_word_t node_wdata;
    logic                q_we, q_re;
    logic [AW-1:0]       q_waddr, q_raddr;
    logic [IW-1:0]       q_wdata;
    logic                push_en;
    logic [IW-1:0]       push_id;

    // Derived values
    logic [CW-1:0] n_eff;
    logic [IW-1:0] leaf;
    logic [IW-1:0] nb_cur;
    logic          a_in, b_in, leaf_in, nb_in;
    logic [PW-1:0] q_count;

    assign n_eff   = (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : node_count_reg;
    assign leaf    = q_rdata_reg;
    assign nb_cur  = node_rdata_reg.nxor;
    assign a_in    = 32'(edge_a_reg) < MAX_NODES;
    assign b_in    = 32'(edge_b_reg) < MAX_NODES;
    assign leaf_in = 32'(leaf) < MAX_NODES;
    assign nb_in   = 32'(nb_cur) < MAX_NODES;
    assign q_count = tail_reg - head_reg;

    // Status back to the controller
    always_comb begin
        status.in_range   = a_in && b_in;
        status.n_zero     = (n_eff == '0);
        status.n_one      = (n_eff == CW'(1));
        status.scan_done  = (scan_cnt_reg == n_eff) && !pend_reg;
        status.peel_go    = (nodes_left_reg > CW'(2)) && (head_reg < tail_reg);
        status.round_busy = (head_reg < round_end_reg);
        status.leaf_ok    = leaf_in && (node_rdata_reg.deg != '0) && nb_in;
        status.q_empty    = (q_count == '0);
        status.q_one      = (q_count == PW'(1));
        status.clr_last   = (clr_addr_reg == AW'(MAX_NODES - 1));
    end

    // Operation decode and next state
    always_comb begin
        node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;
        edge_a_next     = edge_a_reg;
        edge_b_next     = edge_b_reg;
        clr_addr_next   = clr_addr_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_next       = pend_reg;
        pend_id_next    = pend_id_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        round_end_next  = round_end_reg;
        taken_next      = taken_reg;
        nodes_left_next = nodes_left_reg;
        nb_next         = nb_reg;
        center_next     = center_reg;
        last_next       = last_reg;

        node_we    = 1'b0;
        node_re    = 1'b0;
        node_waddr = '0;
        node_raddr = '0;
        node_wdata = '0;
        q_re       = 1'b0;
        q_raddr    = AW'(head_reg);
        push_en    = 1'b0;
        push_id    = '0;

        unique case (op)
            tcp_pkg::OP_NONE: begin
            end
            tcp_pkg::OP_CLEAR: begin
                node_we         = 1'b1;
                node_waddr      = clr_addr_reg;
                clr_addr_next   = status.clr_last ? '0 : clr_addr_reg + AW'(1);
                head_next       = '0;
                tail_next       = '0;
                nodes_left_next = '0;
            end
            tcp_pkg::OP_CAPTURE: begin
                edge_a_next = s_edge_a;
                edge_b_next = s_edge_b;
            end
            tcp_pkg::OP_LD_RD_A: begin
                node_re    = 1'b1;
                node_raddr = AW'(edge_a_reg);
            end
            tcp_pkg::OP_LD_WR_A: begin
                node_we         = 1'b1;
                node_waddr      = AW'(edge_a_reg);
                node_wdata.deg  = node_rdata_reg.deg + DW'(1);
                node_wdata.nxor = node_rdata_reg.nxor ^ edge_b_reg;
            end
            tcp_pkg::OP_LD_RD_B: begin
                node_re    = 1'b1;
                node_raddr = AW'(edge_b_reg);
            end
            tcp_pkg::OP_LD_WR_B: begin
                node_we         = 1'b1;
                node_waddr      = AW'(edge_b_reg);
                node_wdata.deg  = node_rdata_reg.deg + DW'(1);
                node_wdata.nxor = node_rdata_reg.nxor ^ edge_a_reg;
            end
            tcp_pkg::OP_RUN_INIT: begin
                head_next       = '0;
                tail_next       = '0;
                scan_cnt_next   = '0;
                pend_next       = 1'b0;
                nodes_left_next = n_eff;
            end
            tcp_pkg::OP_SCAN: begin
                // issue the next degree lookup, check the one issued last cycle
                if (scan_cnt_reg < n_eff) begin
                    node_re       = 1'b1;
                    node_raddr    = AW'(scan_cnt_reg);
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                    pend_next     = 1'b1;
                    pend_id_next  = scan_cnt_reg;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (node_rdata_reg.deg == DW'(1))) begin
                    push_en = 1'b1;
                    push_id = IW'(pend_id_reg);
                end
            end
            tcp_pkg::OP_ROUND_START: begin
                round_end_next = tail_reg;
                taken_next     = tail_reg - head_reg;
            end
            tcp_pkg::OP_ROUND_END: begin
                // remaining count saturates at zero
                if (LW'(taken_reg) >= LW'(nodes_left_reg)) begin
                    nodes_left_next = '0;
                end else begin
                    nodes_left_next = CW'(LW'(nodes_left_reg) - LW'(taken_reg));
                end
            end
            tcp_pkg::OP_POP_RD: begin
                q_re = 1'b1;
            end
            tcp_pkg::OP_LEAF_RD: begin
                node_re    = 1'b1;
                node_raddr = AW'(leaf);
            end
            tcp_pkg::OP_NB_RD: begin
                node_re    = 1'b1;
                node_raddr = AW'(nb_cur);
                nb_next    = nb_cur;
            end
            tcp_pkg::OP_NB_UPD: begin
                // drop the leaf from its neighbour; a neighbour left with one edge is queued
                node_we         = 1'b1;
                node_waddr      = AW'(nb_reg);
                node_wdata.nxor = node_rdata_reg.nxor ^ leaf;
                node_wdata.deg  = node_rdata_reg.deg;
                if (node_rdata_reg.deg != '0) begin
                    node_wdata.deg = node_rdata_reg.deg - DW'(1);
                end
                if (node_rdata_reg.deg == DW'(2)) begin
                    push_en = 1'b1;
                    push_id = nb_reg;
                end
                head_next = head_reg + PW'(1);
            end
            tcp_pkg::OP_HEAD_INC: begin
                head_next = head_reg + PW'(1);
            end
            tcp_pkg::OP_OUT_ZERO: begin
                center_next = '0;
                last_next   = 1'b1;
            end
            tcp_pkg::OP_OUT_FIRST: begin
                center_next = q_rdata_reg;
                last_next   = status.q_one;
                head_next   = head_reg + PW'(1);
            end
            tcp_pkg::OP_OUT_SECOND: begin
                center_next = q_rdata_reg;
                last_next   = 1'b1;
            end
            default: begin
            end
        endcase

        // queue push at the tail while there is room
        q_we    = 1'b0;
        q_waddr = AW'(tail_reg);
        q_wdata = push_id;
        if (push_en && (tail_reg < PW'(MAX_NODES))) begin
            q_we      = 1'b1;
            tail_next = tail_reg + PW'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CW'(1);
            clr_addr_reg   <= '0;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            round_end_reg  <= '0;
            nodes_left_reg <= '0;
        end else begin
            node_count_reg <= node_count_next;
            clr_addr_reg   <= clr_addr_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_reg       <= pend_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            round_end_reg  <= round_end_next;
            nodes_left_reg <= nodes_left_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        edge_a_reg  <= edge_a_next;
        edge_b_reg  <= edge_b_next;
        pend_id_reg <= pend_id_next;
        taken_reg   <= taken_next;
        nb_reg      <= nb_next;
        center_reg  <= center_next;
        last_reg    <= last_next;
    end

    // Node store: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            node_rdata_reg <= node_mem[node_raddr];
        end
    end

    // Leaf queue: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[q_raddr];
        end
    end

    assign m_center_node = center_reg;
    assign m_last_center = last_reg;

endmodule

@@ src/tcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Tree centre peeling unit: controller
// Sequences edge loads, the leaf scan, peeling rounds, centre emission and
// the store clearing sweep. Owns the input ready and the result valid.
// ----------------------------------------------------------------------------
`include "tree_center_by_leaf_peeling_unit_assert.svh"

module tcp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    output logic                m_valid,
    input  logic                m_ready,
    input  tcp_pkg::dp_status_t status,
    output tcp_pkg::dp_op_t     op
);

    tcp_pkg::ctrl_state_t state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;
    logic                 out_load;

    assign out_free = !m_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcp_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath operation
    always_comb begin
        state_next = state_reg;
        op         = tcp_pkg::OP_NONE;
        s_ready    = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            tcp_pkg::ST_CLEAR: begin
                op = tcp_pkg::OP_CLEAR;
                if (status.clr_last) begin
                    state_next = tcp_pkg::ST_IDLE;
                end
            end
            tcp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = tcp_pkg::OP_CAPTURE;
                    state_next = s_action ? tcp_pkg::ST_RUN_SEL : tcp_pkg::ST_LD_RDA;
                end
            end
            // edge load: read-modify-write of each endpoint in turn
            tcp_pkg::ST_LD_RDA: begin
                if (status.in_range) begin
                    op         = tcp_pkg::OP_LD_RD_A;
                    state_next = tcp_pkg::ST_LD_WRA;
                end else begin
                    state_next = tcp_pkg::ST_IDLE;
                end
            end
            tcp_pkg::ST_LD_WRA: begin
                op         = tcp_pkg::OP_LD_WR_A;
                state_next = tcp_pkg::ST_LD_RDB;
            end
            tcp_pkg::ST_LD_RDB: begin
                op         = tcp_pkg::OP_LD_RD_B;
                state_next = tcp_pkg::ST_LD_WRB;
            end
            tcp_pkg::ST_LD_WRB: begin
                op         = tcp_pkg::OP_LD_WR_B;
                state_next = tcp_pkg::ST_IDLE;
            end
            // run: trivial node counts first
            tcp_pkg::ST_RUN_SEL: begin
                if (status.n_zero) begin
                    state_next = tcp_pkg::ST_CLEAR;
                end else if (status.n_one) begin
                    state_next = tcp_pkg::ST_EMIT_ONE;
                end else begin
                    op         = tcp_pkg::OP_RUN_INIT;
                    state_next = tcp_pkg::ST_SCAN;
                end
            end
            tcp_pkg::ST_EMIT_ONE: begin
                if (out_free) begin
                    op         = tcp_pkg::OP_OUT_ZERO;
                    out_load   = 1'b1;
                    state_next = tcp_pkg::ST_CLEAR;
                end
            end
            tcp_pkg::ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = tcp_pkg::ST_ROUND;
                end else begin
                    op = tcp_pkg::OP_SCAN;
                end
            end
            // peeling rounds
            tcp_pkg::ST_ROUND: begin
                if (status.peel_go) begin
                    op         = tcp_pkg::OP_ROUND_START;
                    state_next = tcp_pkg::ST_POP;
                end else begin
                    state_next = tcp_pkg::ST_EMIT0;
                end
            end
            tcp_pkg::ST_POP: begin
                if (status.round_busy) begin
                    op         = tcp_pkg::OP_POP_RD;
                    state_next = tcp_pkg::ST_POP_WAIT;
                end else begin
                    op         = tcp_pkg::OP_ROUND_END;
                    state_next = tcp_pkg::ST_ROUND;
                end
            end
            tcp_pkg::ST_POP_WAIT: begin
                op         = tcp_pkg::OP_LEAF_RD;
                state_next = tcp_pkg::ST_LEAF_CHK;
            end
            tcp_pkg::ST_LEAF_CHK: begin
                if (status.leaf_ok) begin
                    op         = tcp_pkg::OP_NB_RD;
                    state_next = tcp_pkg::ST_NB_UPD;
                end else begin
                    op         = tcp_pkg::OP_HEAD_INC;
                    state_next = tcp_pkg::ST_POP;
                end
            end
            tcp_pkg::ST_NB_UPD: begin
                op         = tcp_pkg::OP_NB_UPD;
                state_next = tcp_pkg::ST_POP;
            end
            // emit up to two remaining queue entries
            tcp_pkg::ST_EMIT0: begin
                if (status.q_empty) begin
                    state_next = tcp_pkg::ST_CLEAR;
                end else begin
                    op         = tcp_pkg::OP_POP_RD;
                    state_next = tcp_pkg::ST_EMIT0_WAIT;
                end
            end
            tcp_pkg::ST_EMIT0_WAIT: begin
                if (out_free) begin
                    op         = tcp_pkg::OP_OUT_FIRST;
                    out_load   = 1'b1;
                    state_next = status.q_one ? tcp_pkg::ST_CLEAR : tcp_pkg::ST_EMIT1;
                end
            end
            tcp_pkg::ST_EMIT1: begin
                op         = tcp_pkg::OP_POP_RD;
                state_next = tcp_pkg::ST_EMIT1_WAIT;
            end
            tcp_pkg::ST_EMIT1_WAIT: begin
                if (out_free) begin
                    op         = tcp_pkg::OP_OUT_SECOND;
                    out_load   = 1'b1;
                    state_next = tcp_pkg::ST_CLEAR;
                end
            end
            default: begin
                state_next = tcp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Result valid: set on load, dropped once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    // Checks
    `TCP_ASSERT_SAME(a_out_slot_free, aclk, aresetn, (op == tcp_pkg::OP_OUT_FIRST || op == tcp_pkg::OP_OUT_SECOND || op == tcp_pkg::OP_OUT_ZERO), (!m_valid_reg || m_ready), "result register overwritten before it was taken")
    `TCP_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, (s_valid && s_ready), (!s_ready), "second transaction accepted while one is in progress")
    `TCP_ASSERT_SAME(a_valid_from_emit, aclk, aresetn, $rose(m_valid_reg), ($past(state_reg) == tcp_pkg::ST_EMIT_ONE || $past(state_reg) == tcp_pkg::ST_EMIT0_WAIT || $past(state_reg) == tcp_pkg::ST_EMIT1_WAIT), "result raised outside an emit state")
    `TCP_ASSERT_SAME(a_nb_needs_leaf, aclk, aresetn, (op == tcp_pkg::OP_NB_RD), status.leaf_ok, "neighbour fetched for a dead or out-of-range leaf")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree centre peeling unit: self-checking testbench
// Edges are loaded one transaction at a time and a run transaction returns
// the centre nodes. A behavioural copy of the peeling algorithm predicts the
// centres at each accepted run. Each returned centre is checked against the
// oldest prediction. Random idling on both channels, long receiver hold-offs
// and changes of node_count between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ID_W        = tcp_pkg::ID_W;
    localparam int DEG_W       = tcp_pkg::DEG_W;
    localparam int CNT_W       = tcp_pkg::CNT_W;
    localparam int MAXN        = tcp_pkg::MAX_NODES_DEF;
    localparam int ITEM_GOAL   = 1850;
    localparam int LONG_HOLD   = 3000;
    localparam int STALL_LIMIT = 150000;
    localparam bit ACT_LOAD    = 1'b0;
    localparam bit ACT_RUN     = 1'b1;

    typedef struct {
        bit            action;
        bit [ID_W-1:0] end_a;
        bit [ID_W-1:0] end_b;
    } tree_item_t;

    typedef struct {
        bit [ID_W-1:0] node;
        bit            last;
    } centre_t;

    typedef enum {FLAW_RANDOM, FLAW_MISSING, FLAW_EXTRA, FLAW_WIDE} flaw_t;

    // Clock, reset and DUT ports
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data   = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_action      = 1'b0;
    logic [ID_W-1:0]   s_edge_a      = '0;
    logic [ID_W-1:0]   s_edge_b      = '0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [ID_W-1:0]   m_center_node;
    logic              m_last_center;

    always #1 aclk = ~aclk;

    tree_center_by_leaf_peeling_unit #(.MAX_NODES(MAXN)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_edge_a      (s_edge_a),
        .s_edge_b      (s_edge_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_center_node (m_center_node),
        .m_last_center (m_last_center)
    );

    // ------------------------------------------------------------------
    // Peeling predictor: own copy of the node stores and node count
    // ------------------------------------------------------------------
    bit [DEG_W-1:0] deg_mem   [MAXN];
    bit [ID_W-1:0]  nxor_mem  [MAXN];
    bit [ID_W-1:0]  leaf_fifo [MAXN];
    int             leaf_tail;
    int             node_count_cfg = 1;
    centre_t        centres_due[$];

    function automatic void clear_tree();
        foreach (deg_mem[i]) begin
            deg_mem[i]  = '0;
            nxor_mem[i] = '0;
        end
        leaf_tail = 0;
    endfunction

    function automatic void load_edge(int a, int b);
        if (a < MAXN && b < MAXN) begin
            deg_mem[a]  = deg_mem[a] + 1'b1;
            deg_mem[b]  = deg_mem[b] + 1'b1;
            nxor_mem[a] = nxor_mem[a] ^ ID_W'(b);
            nxor_mem[b] = nxor_mem[b] ^ ID_W'(a);
        end
    endfunction

    function automatic void push_leaf(int id);
        if (leaf_tail < MAXN) begin
            leaf_fifo[leaf_tail] = ID_W'(id);
            leaf_tail++;
        end
    endfunction

    // Remove one leaf: its neighbour loses a degree and may become a leaf
    function automatic void peel_leaf(int leaf);
        int nb;
        if (leaf >= MAXN || deg_mem[leaf] == 0)
            return;
        nb = nxor_mem[leaf];
        if (nb >= MAXN)
            return;
        nxor_mem[nb] = nxor_mem[nb] ^ ID_W'(leaf);
        if (deg_mem[nb] != 0) begin
            deg_mem[nb] = deg_mem[nb] - 1'b1;
            if (deg_mem[nb] == 1)
                push_leaf(nb);
        end
    endfunction

    function automatic void find_centres();
        int      n, head, round_end, taken, left, cnt;
        centre_t c;
        n = (node_count_cfg < MAXN) ? node_count_cfg : MAXN;
        if (n == 1) begin
            c.node = '0;
            c.last = 1'b1;
            centres_due = {centres_due, c};
        end else if (n > 1) begin
            leaf_tail = 0;
            head      = 0;
            for (int i = 0; i < n; i++)
                if (deg_mem[i] == 1)
                    push_leaf(i);
            // peel round by round until two or fewer nodes are left
            left = n;
            while (left > 2 && head < leaf_tail) begin
                round_end = leaf_tail;
                taken     = round_end - head;
                while (head < round_end) begin
                    peel_leaf(leaf_fifo[head]);
                    head++;
                end
                left = (taken >= left) ? 0 : left - taken;
            end
            cnt = leaf_tail - head;
            if (cnt > 2)
                cnt = 2;
            for (int i = 0; i < cnt; i++) begin
                c.node = leaf_fifo[head + i];
                c.last = (i + 1 == cnt);
                centres_due = {centres_due, c};
            end
        end
        clear_tree();
    endfunction

    // ------------------------------------------------------------------
    // Idle draws: random idle gaps, with occasional spells of no idling
    // ------------------------------------------------------------------
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued transactions, predicts on acceptance
    // ------------------------------------------------------------------
    tree_item_t pending_items[$];
    tree_item_t next_item;
    int         send_wait;
    int         send_calm;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_calm = 0;
            send_wait = draw_gap(send_calm);
        end else begin
            if (s_valid && s_ready) begin
                if (s_action == ACT_LOAD)
                    load_edge(s_edge_a, s_edge_b);
                else
                    find_centres();
            end
            if (s_valid && !s_ready) begin
                // hold the offered transaction
            end else if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                next_item = pending_items.pop_front();
                s_valid   <= 1'b1;
                s_action  <= next_item.action;
                s_edge_a  <= next_item.end_a;
                s_edge_b  <= next_item.end_b;
                send_wait = draw_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each centre against the oldest prediction
    // ------------------------------------------------------------------
    centre_t want_centre;
    int      recv_wait;
    int      recv_calm;
    int      centres_seen = 0;
    int      hold_mark    = 5;
    int      fail_count   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_calm = 0;
            recv_wait = draw_gap(recv_calm);
        end else begin
            if (m_valid && m_ready) begin
                if (centres_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected centre: node %0d last %0b",
                                 m_center_node, m_last_center);
                end else begin
                    want_centre = centres_due.pop_front();
                    if (m_center_node !== want_centre.node ||
                        m_last_center !== want_centre.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("centre mismatch: expected node %0d last %0b, %s",
                                     want_centre.node, want_centre.last,
                                     $sformatf("got node %0d last %0b",
                                               m_center_node, m_last_center));
                    end
                end
                centres_seen++;
                recv_wait = draw_gap(recv_calm);
                // long hold-off while the second centre is pending and input is offered
                if (!m_last_center && s_valid && centres_seen >= hold_mark) begin
                    recv_wait = LONG_HOLD;
                    hold_mark = centres_seen + 50;
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transaction
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    int perm [MAXN];
    int ea   [MAXN + 4];
    int eb   [MAXN + 4];
    int items_sent = 0;

    function automatic void add_item(bit act, int a, int b);
        tree_item_t it;
        it.action = act;
        it.end_a  = a[ID_W-1:0];
        it.end_b  = b[ID_W-1:0];
        pending_items = {pending_items, it};
        items_sent++;
    endfunction

    function automatic void add_run();
        add_item(ACT_RUN, $urandom_range(0, MAXN - 1), $urandom_range(0, MAXN - 1));
    endfunction

    // Random tree over ids base..base+n-1; span biases towards deep or bushy shapes
    function automatic int build_tree(int n, int base);
        int j, t, span;
        for (int i = 0; i < n; i++)
            perm[i] = base + i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        span = $urandom_range(0, n);
        for (int i = 1; i < n; i++) begin
            j = i - 1 - $urandom_range(0, (span < i) ? span : i - 1);
            ea[i - 1] = perm[i];
            eb[i - 1] = perm[j];
        end
        return (n > 0) ? n - 1 : 0;
    endfunction

    // Shuffle edge order and endpoint order, then queue the loads
    function automatic void emit_edges(int ne);
        int j, t;
        for (int i = ne - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ea[i]; ea[i] = ea[j]; ea[j] = t;
            t = eb[i]; eb[i] = eb[j]; eb[j] = t;
        end
        for (int i = 0; i < ne; i++) begin
            if ($urandom_range(0, 1))
                add_item(ACT_LOAD, eb[i], ea[i]);
            else
                add_item(ACT_LOAD, ea[i], eb[i]);
        end
    endfunction

    function automatic void add_tree(int n, int base);
        emit_edges(build_tree(n, base));
        add_run();
    endfunction

    // Edge sets that are not trees: noise, a missing edge, an extra edge, wide ids
    function automatic void add_broken_tree(int n, int base);
        int    ne, k;
        flaw_t flaw;
        flaw = flaw_t'($urandom_range(0, 3));
        case (flaw)
            FLAW_RANDOM: begin
                ne = $urandom_range(1, n + 2);
                for (int i = 0; i < ne; i++) begin
                    ea[i] = base + $urandom_range(0, n - 1);
                    eb[i] = base + $urandom_range(0, n - 1);
                end
                if ($urandom_range(0, 2) == 0)
                    eb[0] = ea[0];
            end
            FLAW_MISSING: begin
                ne = build_tree(n, base);
                if (ne > 0)
                    ne--;
            end
            FLAW_EXTRA: begin
                ne = build_tree(n, base);
                if (ne > 0 && $urandom_range(0, 1)) begin
                    k = $urandom_range(0, ne - 1);
                    ea[ne] = ea[k];
                    eb[ne] = eb[k];
                end else begin
                    ea[ne] = base + $urandom_range(0, n - 1);
                    eb[ne] = base + $urandom_range(0, n - 1);
                end
                ne++;
            end
            default: begin
                ne = $urandom_range(1, 8);
                for (int i = 0; i < ne; i++) begin
                    ea[i] = $urandom_range(0, MAXN - 1);
                    eb[i] = $urandom_range(0, MAXN - 1);
                end
            end
        endcase
        emit_edges(ne);
        add_run();
    endfunction

    // Wait long enough for a silent run plus the clearing sweep; a run may peel up to
    // twice n leaves, plus the peeling rounds and the scan
    function automatic int settle_cycles();
        int n;
        n = (node_count_cfg < MAXN) ? node_count_cfg : MAXN;
        return 12 * n + MAXN + 200;
    endfunction

    // Everything offered, accepted and answered
    task automatic wait_quiet();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || centres_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic start_phase(int count);
        wait_quiet();
        repeat (settle_cycles()) @(posedge aclk);
        cfg_wr_en      <= 1'b1;
        cfg_wr_data    <= CNT_W'(count);
        node_count_cfg = count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int  cfg, size, base, kind, trees;
    bit  wrap_done = 1'b0;

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // single node: centre 0 whatever was loaded
        start_phase(1);
        add_item(ACT_LOAD, 5, 6);
        add_run();
        // zero nodes: nothing returned, self loop on the top id
        start_phase(0);
        add_item(ACT_LOAD, MAXN - 1, MAXN - 1);
        add_run();
        // two nodes: both returned in index order
        start_phase(2);
        add_item(ACT_LOAD, 1, 0);
        add_run();
        // a cycle: no leaves, peeling stops at once
        start_phase(3);
        add_item(ACT_LOAD, 0, 1);
        add_item(ACT_LOAD, 1, 2);
        add_item(ACT_LOAD, 2, 0);
        add_run();
        // three nodes queued when peeling stops: only the first two returned
        start_phase(4);
        add_item(ACT_LOAD, 0, 4);
        add_item(ACT_LOAD, 1, 5);
        add_item(ACT_LOAD, 2, 6);
        add_item(ACT_LOAD, 4, 7);
        add_item(ACT_LOAD, 5, 7);
        add_item(ACT_LOAD, 6, 7);
        add_run();
        // count above the store, emptied leaves and count underflow
        start_phase(2047);
        add_item(ACT_LOAD, 0, MAXN - 1);
        add_item(ACT_LOAD, MAXN - 1, 512);
        add_run();
        // full store with a short path at the top ids
        start_phase(MAXN);
        add_item(ACT_LOAD, MAXN - 1, MAXN - 2);
        add_item(ACT_LOAD, MAXN - 2, MAXN - 3);
        add_run();

        // random phases, one node count each
        while (items_sent < ITEM_GOAL) begin
            if (!wrap_done && items_sent > ITEM_GOAL / 2) begin
                // degree wraps to zero after 512 self loops, then a path 0-1-2
                wrap_done = 1'b1;
                start_phase(3);
                repeat (512) add_item(ACT_LOAD, 0, 0);
                add_item(ACT_LOAD, 0, 1);
                add_item(ACT_LOAD, 2, 1);
                add_run();
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 5)
                    cfg = $urandom_range(0, 1);
                else if (kind < 10)
                    cfg = $urandom_range(0, 1) ? MAXN : $urandom_range(MAXN, 2047);
                else if (kind < 70)
                    cfg = $urandom_range(2, 10);
                else if (kind < 90)
                    cfg = $urandom_range(11, 40);
                else
                    cfg = $urandom_range(41, 120);
                start_phase(cfg);
                trees = $urandom_range(2, 6);
                for (int t = 0; t < trees && items_sent < ITEM_GOAL; t++) begin
                    base = 0;
                    if (cfg > 120) begin
                        size = $urandom_range(2, 30);
                        base = $urandom_range(0, MAXN - size);
                    end else if (cfg < 2) begin
                        size = $urandom_range(1, 4);
                    end else begin
                        size = cfg;
                    end
                    if ($urandom_range(0, 4) == 0)
                        add_broken_tree(size, base);
                    else
                        add_tree(size, base);
                end
            end
        end

        wait_quiet();
        repeat (settle_cycles()) @(posedge aclk);
        if (fail_count == 0 && centres_due.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
